// File: sv/length_prefixed_frame_deframer_top_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LPFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/lpfd_pkg.sv
// Shared types, codes and the byte-wide CRC-32 update for the frame deframer.
package lpfd_pkg;

    // Parse phases.
    localparam logic [2:0] PH_LEN_HI   = 3'd0;
    localparam logic [2:0] PH_LEN_LO   = 3'd1;
    localparam logic [2:0] PH_PREAMBLE = 3'd2;
    localparam logic [2:0] PH_DEST     = 3'd3;
    localparam logic [2:0] PH_SRC      = 3'd4;
    localparam logic [2:0] PH_TYPE     = 3'd5;
    localparam logic [2:0] PH_PAYLOAD  = 3'd6;
    localparam logic [2:0] PH_CRC      = 3'd7;

    // Byte roles.
    localparam logic [2:0] ROLE_DEST    = 3'd0;
    localparam logic [2:0] ROLE_SRC     = 3'd1;
    localparam logic [2:0] ROLE_TYPE    = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_STATUS  = 3'd4;

    // Frame status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_BAD_CRC  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_PAYLOAD = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd1;

    // Register reset values.
    localparam logic [15:0] MIN_PAYLOAD_RESET = 16'd46;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1500;

    // Header field lengths, as last byte index within each phase.
    localparam logic [15:0] PREAMBLE_LAST = 16'd7;
    localparam logic [15:0] ADDR_LAST     = 16'd5;
    localparam logic [15:0] TYPE_LAST     = 16'd1;
    localparam logic [15:0] CRC_LAST      = 16'd3;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_role;
        logic [1:0] frame_status;
        logic       frame_end;
    } t_result;

    // Request from the parser into the output queue.
    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

    // Reflected CRC-32 update by one byte, one bit per step.
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: sv/lpfd_parser.sv
// Frame parser: phase tracking, length range check, CRC accumulation.
module lpfd_parser
    import lpfd_pkg::*;
#(
    parameter logic [15:0] MIN_RESET = MIN_PAYLOAD_RESET,
    parameter logic [15:0] MAX_RESET = MAX_PAYLOAD_RESET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [7:0]  i_byte,
    output t_push       o_push
);
`include "length_prefixed_frame_deframer_top_macros.svh"

    logic [15:0] r_min, r_max;
    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [15:0] r_len, n_len;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rx_crc, n_rx_crc;
    logic        accept;
    logic [15:0] len_full;
    logic [31:0] rx_crc_full;

    assign accept      = i_valid & i_ready;
    assign len_full    = {r_len[15:8], i_byte};
    assign rx_crc_full = {r_rx_crc[23:0], i_byte};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_PAYLOAD: r_min <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and result for the byte on the input.
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_len    = r_len;
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;
        o_push   = '0;
        unique case (r_phase)
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'd0};
                n_count = '0;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = len_full;
                n_count = '0;
                if (len_full < r_min || len_full > r_max) begin
                    n_phase = PH_LEN_HI;
                    o_push.valid = 1'b1;
                    o_push.data  = '{8'd0, ROLE_STATUS, ST_BAD_SIZE, 1'b1};
                end else begin
                    n_crc    = CRC_INIT;
                    n_rx_crc = '0;
                    n_phase  = PH_PREAMBLE;
                end
            end
            PH_PREAMBLE: begin
                if (r_count >= PREAMBLE_LAST) begin
                    n_count = '0;
                    n_phase = PH_DEST;
                end else begin
                    n_count = r_count + 16'd1;
                end
            end
            PH_DEST: begin
                if (r_count >= ADDR_LAST) begin
                    n_count = '0;
                    n_phase = PH_SRC;
                end else begin
                    n_count = r_count + 16'd1;
                end
                o_push.valid = 1'b1;
                o_push.data  = '{i_byte, ROLE_DEST, ST_OK, 1'b0};
            end
            PH_SRC: begin
                if (r_count >= ADDR_LAST) begin
                    n_count = '0;
                    n_phase = PH_TYPE;
                end else begin
                    n_count = r_count + 16'd1;
                end
                o_push.valid = 1'b1;
                o_push.data  = '{i_byte, ROLE_SRC, ST_OK, 1'b0};
            end
            PH_TYPE: begin
                if (r_count >= TYPE_LAST) begin
                    n_count = '0;
                    n_phase = (r_len == 16'd0) ? PH_CRC : PH_PAYLOAD;
                end else begin
                    n_count = r_count + 16'd1;
                end
                o_push.valid = 1'b1;
                o_push.data  = '{i_byte, ROLE_TYPE, ST_OK, 1'b0};
            end
            PH_PAYLOAD: begin
                n_crc = crc32_byte(r_crc, i_byte);
                if (({1'b0, r_count} + 17'd1) >= {1'b0, r_len}) begin
                    n_count = '0;
                    n_phase = PH_CRC;
                end else begin
                    n_count = r_count + 16'd1;
                end
                o_push.valid = 1'b1;
                o_push.data  = '{i_byte, ROLE_PAYLOAD, ST_OK, 1'b0};
            end
            PH_CRC: begin
                n_rx_crc = rx_crc_full;
                if (r_count >= CRC_LAST) begin
                    n_count = '0;
                    n_phase = PH_LEN_HI;
                    o_push.valid = 1'b1;
                    o_push.data  = '{8'd0, ROLE_STATUS,
                                     (rx_crc_full == ~r_crc) ? ST_OK : ST_BAD_CRC, 1'b1};
                end else begin
                    n_count = r_count + 16'd1;
                end
            end
            default: ;
        endcase
        // Only an accepted byte produces a request.
        o_push.valid = o_push.valid & accept;
    end

    // Parse state advances on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEN_HI;
            r_count  <= '0;
            r_len    <= '0;
            r_crc    <= CRC_INIT;
            r_rx_crc <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_len    <= n_len;
            r_crc    <= n_crc;
            r_rx_crc <= n_rx_crc;
        end
    end

    // A frame's last CRC byte always closes the frame and restarts length parsing.
    `LPFD_ASSERT_NEXT(a_crc_end_restarts,
        accept && r_phase == PH_CRC && r_count == CRC_LAST,
        r_phase == PH_LEN_HI, "CRC end did not return to length phase")

    // A status-only result always ends the frame, and nothing else ends it.
    `LPFD_ASSERT_NOW(a_status_ends_frame, o_push.valid,
        (o_push.data.byte_role == ROLE_STATUS) == o_push.data.frame_end,
        "frame end and status role disagree")

    // The preamble counter never runs past its last byte.
    `LPFD_ASSERT_NOW(a_preamble_count, r_phase == PH_PREAMBLE,
        r_count <= PREAMBLE_LAST, "preamble counter overran")

endmodule

// File: sv/lpfd_out_queue.sv
// Two-entry output queue that decouples the parser from a stalling receiver.
module lpfd_out_queue
    import lpfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);
`include "length_prefixed_frame_deframer_top_macros.svh"

    t_result     r_mem [2];
    logic        r_head, r_tail;
    logic [1:0]  r_count;
    logic        pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid & i_ready;
    assign o_data  = r_mem[r_head];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_tail] <= i_push.data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_tail <= ~r_tail;
            end
            if (pop) begin
                r_head <= ~r_head;
            end
            r_count <= r_count + {1'b0, i_push.valid} - {1'b0, pop};
        end
    end

    `LPFD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= 2'd2, "queue count above depth")

    `LPFD_ASSERT_NOW(a_no_push_full, i_push.valid, r_count != 2'd2, "request into full queue")

    `LPFD_ASSERT_NOW(a_ptr_count, 1'b1,
        (r_count == 2'd1) == (r_head != r_tail), "pointers disagree with count")

endmodule

// File: sv/length_prefixed_frame_deframer_top.sv
// Top level of the length-prefixed frame deframer.
//
// Usage:
//   s_axis carries the received byte stream, one byte per request in tdata.
//   Each frame is a 2-byte big-endian length, 8 preamble bytes, 6 destination,
//   6 source and 2 type bytes, the payload and a 4-byte big-endian CRC-32 over
//   the payload. Address, type and payload bytes leave on m_axis with their
//   role in tuser; the last CRC byte gives a status-only result with tlast set.
//   A length outside [min_payload, max_payload] gives a bad-size status at once.
//   The receiver drops a frame whose final status is not ok.
//   The config port writes min_payload (index 0) and max_payload (index 1); the
//   user must write them only while the block is idle; the block does not enforce it.
// Throughput: a result is written into the output queue when its byte is
//   accepted; one byte per cycle is sustained while the queue has room, set by the
//   byte-wide CRC update and phase counter, which both finish in the accepting cycle.
// Reset: the parser waits for a length high byte, the queue is empty and the
//   ranges return to MIN_RESET and MAX_RESET, 46 and 1500 by default.
// Stalls: a two-entry output queue keeps taking bytes while one result waits;
//   s_axis_tready drops only when both entries are full.
module length_prefixed_frame_deframer_top
    import lpfd_pkg::*;
#(
    parameter logic [15:0] MIN_RESET = MIN_PAYLOAD_RESET,
    parameter logic [15:0] MAX_RESET = MAX_PAYLOAD_RESET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [4:0]  m_axis_tuser,   // [2:0] byte_role, [4:3] frame_status
    output logic        m_axis_tlast    // frame_end
);

    t_push   push;
    t_result out_res;

    // Parser consumes bytes while the queue has room.
    lpfd_parser #(
        .MIN_RESET(MIN_RESET),
        .MAX_RESET(MAX_RESET)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .o_push     (push)
    );

    // Output queue feeds the master side.
    lpfd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tuser = {out_res.frame_status, out_res.byte_role};
    assign m_axis_tlast = out_res.frame_end;

endmodule
